### src/lli_pkg.sv
package lli_pkg;

  // Default coordinate width; the fraction position does not change the datapath.
  localparam int COORD_WIDTH = 16;

  // Width of the parallel threshold register.
  localparam int LIMIT_WIDTH = 16;

  // Control that travels with each item from stage to stage.
  typedef struct packed {
    logic valid;
    logic found;
  } lli_ctl_t;

endpackage

### src/lli_front.sv
module lli_front #(
  parameter int CW = lli_pkg::COORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [CW-1:0]            a_start_x_i,
  input  logic signed [CW-1:0]            a_start_y_i,
  input  logic signed [CW-1:0]            a_end_x_i,
  input  logic signed [CW-1:0]            a_end_y_i,
  input  logic signed [CW-1:0]            b_start_x_i,
  input  logic signed [CW-1:0]            b_start_y_i,
  input  logic signed [CW-1:0]            b_end_x_i,
  input  logic signed [CW-1:0]            b_end_y_i,
  input  logic [lli_pkg::LIMIT_WIDTH-1:0] limit_i,
  output lli_pkg::lli_ctl_t               ctl_o,
  output logic [2*CW:0]                   den_o,
  output logic [3*CW:0]                   mag_x_o,
  output logic [3*CW:0]                   mag_y_o,
  output logic                            neg_x_o,
  output logic                            neg_y_o,
  output logic signed [CW-1:0]            base_x_o,
  output logic signed [CW-1:0]            base_y_o
);
  import lli_pkg::*;

  localparam int DIFW = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int SW   = 2 * CW + 3;
  localparam int DW   = 2 * CW + 1;
  localparam int MW   = 3 * CW + 1;

  // Stage 1: differences.
  logic                   v1_q;
  logic signed [DIFW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, wx_q, wy_q;
  logic signed [CW-1:0]   bx1_q, by1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1x_q <= {a_end_x_i[CW-1], a_end_x_i} - {a_start_x_i[CW-1], a_start_x_i};
      d1y_q <= {a_end_y_i[CW-1], a_end_y_i} - {a_start_y_i[CW-1], a_start_y_i};
      d2x_q <= {b_end_x_i[CW-1], b_end_x_i} - {b_start_x_i[CW-1], b_start_x_i};
      d2y_q <= {b_end_y_i[CW-1], b_end_y_i} - {b_start_y_i[CW-1], b_start_y_i};
      wx_q  <= {a_start_x_i[CW-1], a_start_x_i} - {b_start_x_i[CW-1], b_start_x_i};
      wy_q  <= {a_start_y_i[CW-1], a_start_y_i} - {b_start_y_i[CW-1], b_start_y_i};
      bx1_q <= a_start_x_i;
      by1_q <= a_start_y_i;
    end
  end

  // Stage 2: the four cross products.
  logic                   v2_q;
  logic signed [PW-1:0]   pa_q, pb_q, pc_q, pd_q;
  logic signed [DIFW-1:0] d1x2_q, d1y2_q;
  logic signed [CW-1:0]   bx2_q, by2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= PW'(d1x_q) * PW'(d2y_q);
      pb_q   <= PW'(d2x_q) * PW'(d1y_q);
      pc_q   <= PW'(d2x_q) * PW'(wy_q);
      pd_q   <= PW'(d2y_q) * PW'(wx_q);
      d1x2_q <= d1x_q;
      d1y2_q <= d1y_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
    end
  end

  // Stage 3: denominator, numerator, parallel test, signs and magnitudes.
  logic signed [SW-1:0]   den_s, num_s;
  logic        [SW-1:0]   den_abs, num_abs;
  logic        [DIFW-1:0] dx_abs, dy_abs;
  logic                   found3_d;

  assign den_s    = {pa_q[PW-1], pa_q} - {pb_q[PW-1], pb_q};
  assign num_s    = {pc_q[PW-1], pc_q} - {pd_q[PW-1], pd_q};
  assign den_abs  = den_s[SW-1] ? -den_s : den_s;
  assign num_abs  = num_s[SW-1] ? -num_s : num_s;
  assign dx_abs   = d1x2_q[DIFW-1] ? -d1x2_q : d1x2_q;
  assign dy_abs   = d1y2_q[DIFW-1] ? -d1y2_q : d1y2_q;
  assign found3_d = den_abs[DW-1:0] > {{(DW-LIMIT_WIDTH){1'b0}}, limit_i};

  lli_ctl_t             ctl3_q;
  logic [DW-1:0]        den3_q, nmag_q;
  logic                 nneg_q, dxneg_q, dyneg_q;
  logic [CW-1:0]        dxmag_q, dymag_q;
  logic signed [CW-1:0] bx3_q, by3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en_i) begin
      ctl3_q.valid <= v2_q;
      ctl3_q.found <= found3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den3_q  <= den_abs[DW-1:0];
      nmag_q  <= num_abs[DW-1:0];
      nneg_q  <= num_s[SW-1] ^ den_s[SW-1];
      dxmag_q <= dx_abs[CW-1:0];
      dymag_q <= dy_abs[CW-1:0];
      dxneg_q <= d1x2_q[DIFW-1];
      dyneg_q <= d1y2_q[DIFW-1];
      bx3_q   <= bx2_q;
      by3_q   <= by2_q;
    end
  end

  // Stage 4: scale the numerator by each direction component.
  lli_ctl_t ctl4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_o  <= MW'(nmag_q) * MW'(dxmag_q);
      mag_y_o  <= MW'(nmag_q) * MW'(dymag_q);
      neg_x_o  <= nneg_q ^ dxneg_q;
      neg_y_o  <= nneg_q ^ dyneg_q;
      den_o    <= den3_q;
      base_x_o <= bx3_q;
      base_y_o <= by3_q;
    end
  end

  assign ctl_o = ctl4_q;

endmodule

### src/lli_div.sv
module lli_div #(
  parameter int CW = lli_pkg::COORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  lli_pkg::lli_ctl_t    ctl_i,
  input  logic [2*CW:0]        den_i,
  input  logic [3*CW:0]        mag_x_i,
  input  logic [3*CW:0]        mag_y_i,
  input  logic                 neg_x_i,
  input  logic                 neg_y_i,
  input  logic signed [CW-1:0] base_x_i,
  input  logic signed [CW-1:0] base_y_i,
  output lli_pkg::lli_ctl_t    ctl_o,
  output logic [CW-1:0]        quo_x_o,
  output logic [CW-1:0]        quo_y_o,
  output logic                 ovf_x_o,
  output logic                 ovf_y_o,
  output logic                 neg_x_o,
  output logic                 neg_y_o,
  output logic signed [CW-1:0] base_x_o,
  output logic signed [CW-1:0] base_y_o
);
  import lli_pkg::*;

  localparam int DW     = 2 * CW + 1;
  localparam int MW     = 3 * CW + 1;
  localparam int NSTAGE = CW + 1;

  lli_ctl_t      ctl_q  [NSTAGE];
  logic [DW-1:0] den_q  [NSTAGE];
  logic [DW-1:0] rem_q  [NSTAGE][2];
  // Holds the numerator bits still to be brought down; quotient bits shift in below them.
  logic [CW-1:0] acc_q  [NSTAGE][2];
  logic          ovf_q  [NSTAGE][2];
  logic          neg_q  [NSTAGE][2];
  logic [CW-1:0] base_q [NSTAGE][2];

  logic [MW-1:0] mag_in  [2];
  logic          neg_in  [2];
  logic [CW-1:0] base_in [2];

  assign mag_in[0]  = mag_x_i;
  assign mag_in[1]  = mag_y_i;
  assign neg_in[0]  = neg_x_i;
  assign neg_in[1]  = neg_y_i;
  assign base_in[0] = base_x_i;
  assign base_in[1] = base_y_i;

  // Stage 0: a quotient of 2^CW or more always saturates, so only the
  // upper part is compared and the low CW quotient bits are developed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_init
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l]  <= mag_in[l][MW-1:CW];
        ovf_q[0][l]  <= mag_in[l][MW-1:CW] >= den_i;
        acc_q[0][l]  <= mag_in[l][CW-1:0];
        neg_q[0][l]  <= neg_in[l];
        base_q[0][l] <= base_in[l];
      end
    end
  end

  // One restoring step per stage.
  for (genvar s = 0; s < CW; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        take;

      assign trial = {rem_q[s][l], acc_q[s][l][CW-1]};
      assign diff  = trial - {1'b0, den_q[s]};
      assign take  = trial >= {1'b0, den_q[s]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1][l]  <= take ? diff[DW-1:0] : trial[DW-1:0];
          acc_q[s+1][l]  <= {acc_q[s][l][CW-2:0], take};
          ovf_q[s+1][l]  <= ovf_q[s][l];
          neg_q[s+1][l]  <= neg_q[s][l];
          base_q[s+1][l] <= base_q[s][l];
        end
      end
    end
  end

  assign ctl_o    = ctl_q[CW];
  assign quo_x_o  = acc_q[CW][0];
  assign quo_y_o  = acc_q[CW][1];
  assign ovf_x_o  = ovf_q[CW][0];
  assign ovf_y_o  = ovf_q[CW][1];
  assign neg_x_o  = neg_q[CW][0];
  assign neg_y_o  = neg_q[CW][1];
  assign base_x_o = base_q[CW][0];
  assign base_y_o = base_q[CW][1];

endmodule

### src/line_line_intersection.sv
// Intersection of two lines, each given by two points in signed fixed point.
// Input channel: in_valid_i / in_ready_o carry one item, the eight endpoint
// coordinates of both lines. Output channel: out_valid_o / out_ready_i carry
// one result per item: found, the intersection cross_x / cross_y, and clipped
// when a coordinate saturated to the coordinate range.
// The threshold parallel_limit is written through cfg_we_i / cfg_wdata_i; it is
// applied to the magnitude of the cross-product denominator, and a pair at or
// below it is reported as parallel with all other fields zero.
// The pipeline has four front stages for differences, products, denominator
// and scaling, one compare stage and COORD_WIDTH stages of the restoring
// divider (one quotient bit per stage, both coordinates in parallel), then
// the output register.
// Throughput is one item per cycle. When the receiver stalls, the whole
// pipeline holds and in_ready_o drops until the waiting result is taken;
// nothing is lost or repeated.
// Reset clears all valid bits and sets parallel_limit to zero.
module line_line_intersection #(
  parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lli_pkg::LIMIT_WIDTH-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]   a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   a_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]   b_end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic signed [COORD_WIDTH-1:0]   cross_x_o,
  output logic signed [COORD_WIDTH-1:0]   cross_y_o,
  output logic                            clipped_o
);
  import lli_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * CW + 1;
  localparam int MW = 3 * CW + 1;
  localparam int VW = CW + 2;

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // The pipeline advances whenever the output register is free or being read.
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [LIMIT_WIDTH-1:0] parallel_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parallel_limit_q <= '0;
    end else if (cfg_we_i) begin
      parallel_limit_q <= cfg_wdata_i;
    end
  end

  // Front end: differences, cross products, parallel test and scaling.
  lli_ctl_t             f_ctl;
  logic [DW-1:0]        f_den;
  logic [MW-1:0]        f_mag_x, f_mag_y;
  logic                 f_neg_x, f_neg_y;
  logic signed [CW-1:0] f_base_x, f_base_y;

  lli_front #(
    .CW (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .limit_i     (parallel_limit_q),
    .ctl_o       (f_ctl),
    .den_o       (f_den),
    .mag_x_o     (f_mag_x),
    .mag_y_o     (f_mag_y),
    .neg_x_o     (f_neg_x),
    .neg_y_o     (f_neg_y),
    .base_x_o    (f_base_x),
    .base_y_o    (f_base_y)
  );

  // Divider: magnitude of the offset along each axis.
  lli_ctl_t             d_ctl;
  logic [CW-1:0]        d_quo_x, d_quo_y;
  logic                 d_ovf_x, d_ovf_y;
  logic                 d_neg_x, d_neg_y;
  logic signed [CW-1:0] d_base_x, d_base_y;

  lli_div #(
    .CW (CW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (f_ctl),
    .den_i    (f_den),
    .mag_x_i  (f_mag_x),
    .mag_y_i  (f_mag_y),
    .neg_x_i  (f_neg_x),
    .neg_y_i  (f_neg_y),
    .base_x_i (f_base_x),
    .base_y_i (f_base_y),
    .ctl_o    (d_ctl),
    .quo_x_o  (d_quo_x),
    .quo_y_o  (d_quo_y),
    .ovf_x_o  (d_ovf_x),
    .ovf_y_o  (d_ovf_y),
    .neg_x_o  (d_neg_x),
    .neg_y_o  (d_neg_y),
    .base_x_o (d_base_x),
    .base_y_o (d_base_y)
  );

  // Final stage: apply the offset to the start point and saturate. The sum
  // fits in CW+2 bits; it is out of range exactly when its top three bits
  // are not all equal.
  logic [VW-1:0] sum_x, sum_y;
  logic [CW-1:0] sat_x, sat_y;
  logic          clip_x, clip_y;

  assign sum_x = d_neg_x ? {{2{d_base_x[CW-1]}}, d_base_x} - {2'b00, d_quo_x}
                         : {{2{d_base_x[CW-1]}}, d_base_x} + {2'b00, d_quo_x};
  assign sum_y = d_neg_y ? {{2{d_base_y[CW-1]}}, d_base_y} - {2'b00, d_quo_y}
                         : {{2{d_base_y[CW-1]}}, d_base_y} + {2'b00, d_quo_y};

  always_comb begin
    clip_x = 1'b1;
    if (d_ovf_x) begin
      sat_x = d_neg_x ? CMIN : CMAX;
    end else if (!sum_x[VW-1] && (sum_x[VW-2:CW-1] != 2'b00)) begin
      sat_x = CMAX;
    end else if (sum_x[VW-1] && (sum_x[VW-2:CW-1] != 2'b11)) begin
      sat_x = CMIN;
    end else begin
      sat_x  = sum_x[CW-1:0];
      clip_x = 1'b0;
    end
  end

  always_comb begin
    clip_y = 1'b1;
    if (d_ovf_y) begin
      sat_y = d_neg_y ? CMIN : CMAX;
    end else if (!sum_y[VW-1] && (sum_y[VW-2:CW-1] != 2'b00)) begin
      sat_y = CMAX;
    end else if (sum_y[VW-1] && (sum_y[VW-2:CW-1] != 2'b11)) begin
      sat_y = CMIN;
    end else begin
      sat_y  = sum_y[CW-1:0];
      clip_y = 1'b0;
    end
  end

  logic          found_q, clipped_q;
  logic [CW-1:0] cross_x_q, cross_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_ctl.valid;
    end
  end

  // A parallel pair reports zeros in every field.
  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q   <= d_ctl.found;
      cross_x_q <= d_ctl.found ? sat_x : '0;
      cross_y_q <= d_ctl.found ? sat_y : '0;
      clipped_q <= d_ctl.found && (clip_x || clip_y);
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign cross_x_o   = cross_x_q;
  assign cross_y_o   = cross_y_q;
  assign clipped_o   = clipped_q;

`ifndef ASSERT_OFF
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (cross_x_o == '0 && cross_y_o == '0 && !clipped_o))
    else $error("parallel result carries nonzero fields");

  a_clip_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (cross_x_q == CMAX || cross_x_q == CMIN ||
                                    cross_y_q == CMAX || cross_y_q == CMIN))
    else $error("clipped result without a saturated coordinate");

  a_found_nonzero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_ctl.valid && f_ctl.found) |-> (f_den != '0))
    else $error("intersection reported with a zero denominator");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(d_ctl) && $stable(f_ctl)))
    else $error("pipeline moved during an output stall");
`endif

endmodule
